>>> design/annexb_pkg.sv
`timescale 1ns / 1ps
package annexb_pkg;

    // Width of the internal byte counters; offsets wrap at this width.
    localparam int POS_BITS    = 24;
    // Width of the reported offset and size fields.
    localparam int FIELD_W     = 24;
    localparam int TYPE_W      = 5;

    localparam logic [7:0]        START_TAIL     = 8'h01;
    localparam logic [7:0]        ZERO_BYTE      = 8'h00;
    localparam logic [TYPE_W-1:0] NAL_TYPE_SLICE = 5'd1;
    localparam logic [TYPE_W-1:0] NAL_TYPE_IDR   = 5'd5;
    localparam logic [TYPE_W-1:0] NAL_TYPE_NONE  = 5'd0;

    localparam logic [1:0] ZERO_RUN_MAX = 2'd3;

    localparam logic STATUS_UNIT     = 1'b0;
    localparam logic STATUS_NO_START = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef logic [POS_BITS-1:0] pos_t;

    typedef struct packed {
        logic [TYPE_W-1:0]  unit_type;
        logic [FIELD_W-1:0] unit_offset;
        logic [FIELD_W-1:0] unit_size;
        logic               status;
        logic               last_result;
    } desc_t;

    // One queue entry: the results caused by one byte, one or two of them.
    typedef struct packed {
        logic  two_results;
        desc_t first;
        desc_t second;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } queue_ctl_t;

    function automatic logic [FIELD_W-1:0] to_field(input pos_t pos);
        logic [FIELD_W+POS_BITS-1:0] ext;
        ext = {{FIELD_W{1'b0}}, pos};
        return ext[FIELD_W-1:0];
    endfunction

endpackage

>>> design/annexb_if.sv
`timescale 1ns / 1ps
interface annexb_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface annexb_unit_if;
    logic        valid;
    logic        ready;
    logic [4:0]  unit_type;
    logic [23:0] unit_offset;
    logic [23:0] unit_size;
    logic        status;
    logic        last_result;

    modport source (output valid, output unit_type, output unit_offset, output unit_size,
                    output status, output last_result, input ready);
    modport sink   (input valid, input unit_type, input unit_offset, input unit_size,
                    input status, input last_result, output ready);
endinterface

>>> design/annexb_front.sv
`timescale 1ns / 1ps
module annexb_front
    import annexb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               end_of_buffer,
    input  logic               queue_full,
    output logic               push,
    output entry_t             push_entry
);

    logic [1:0]        zero_run_reg, zero_run_next;
    pos_t              pos_reg, pos_next;
    pos_t              start_reg, start_next;
    logic [TYPE_W-1:0] type_reg, type_next;
    logic              open_reg, open_next;
    logic              pend_reg, pend_next;
    logic              slice_reg, slice_next;

    logic  accept;
    logic  scan;
    logic  close_prev;
    desc_t prev_desc;
    desc_t final_desc;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        zero_run_next = zero_run_reg;
        pos_next      = pos_reg;
        start_next    = start_reg;
        type_next     = type_reg;
        open_next     = open_reg;
        pend_next     = pend_reg;
        slice_next    = slice_reg;
        scan          = 1'b0;
        close_prev    = 1'b0;
        prev_desc     = '0;
        final_desc    = '0;

        if (accept)
        begin
            if (!slice_reg)
            begin
                scan = 1'b1;
                if (pend_reg)
                begin
                    type_next = data_byte[TYPE_W-1:0];
                    pend_next = 1'b0;
                    if (type_next inside {NAL_TYPE_SLICE, NAL_TYPE_IDR})
                    begin
                        slice_next = 1'b1;
                        scan       = 1'b0;
                    end
                end
            end

            if (scan)
            begin
                if (data_byte == ZERO_BYTE)
                begin
                    if (zero_run_reg != ZERO_RUN_MAX)
                        zero_run_next = zero_run_reg + 2'd1;
                end
                else if (data_byte == START_TAIL && zero_run_reg == ZERO_RUN_MAX)
                begin
                    if (open_reg)
                    begin
                        // Previous unit ends where the 4-byte start code began.
                        close_prev            = 1'b1;
                        prev_desc.unit_type   = type_next;
                        prev_desc.unit_offset = to_field(start_reg);
                        prev_desc.unit_size   = to_field(pos_reg - pos_t'(3) - start_reg);
                        prev_desc.status      = STATUS_UNIT;
                        prev_desc.last_result = 1'b0;
                    end
                    open_next     = 1'b1;
                    pend_next     = 1'b1;
                    start_next    = pos_reg + pos_t'(1);
                    type_next     = NAL_TYPE_NONE;
                    zero_run_next = '0;
                end
                else
                begin
                    zero_run_next = '0;
                end
            end

            if (end_of_buffer)
            begin
                if (open_next)
                begin
                    final_desc.unit_type   = pend_next ? NAL_TYPE_NONE : type_next;
                    final_desc.unit_offset = to_field(start_next);
                    final_desc.unit_size   = to_field(pos_reg + pos_t'(1) - start_next);
                    final_desc.status      = STATUS_UNIT;
                end
                else
                begin
                    final_desc.status      = STATUS_NO_START;
                end
                final_desc.last_result = 1'b1;

                zero_run_next = '0;
                pos_next      = '0;
                start_next    = '0;
                type_next     = NAL_TYPE_NONE;
                open_next     = 1'b0;
                pend_next     = 1'b0;
                slice_next    = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + pos_t'(1);
            end
        end
    end

    always_comb
    begin
        push                   = accept && (close_prev || end_of_buffer);
        push_entry.two_results = close_prev && end_of_buffer;
        push_entry.first       = close_prev ? prev_desc : final_desc;
        push_entry.second      = final_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_run_reg <= '0;
            pos_reg      <= '0;
            start_reg    <= '0;
            type_reg     <= NAL_TYPE_NONE;
            open_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            slice_reg    <= 1'b0;
        end
        else
        begin
            zero_run_reg <= zero_run_next;
            pos_reg      <= pos_next;
            start_reg    <= start_next;
            type_reg     <= type_next;
            open_reg     <= open_next;
            pend_reg     <= pend_next;
            slice_reg    <= slice_next;
        end
    end

    a_pend_needs_open: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> open_reg)
        else $error("type pending without open unit");

    a_slice_needs_open: assert property (@(posedge clk) disable iff (!rst_n)
        slice_reg |-> (open_reg && !pend_reg))
        else $error("slice state without typed open unit");

endmodule

>>> design/annexb_queue.sv
`timescale 1ns / 1ps
module annexb_queue
    import annexb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  entry_t     push_entry,
    input  logic       pop,
    output entry_t     pop_entry,
    output queue_ctl_t ctl
);

    entry_t                 mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign ctl.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign ctl.empty = (count_reg == '0);
    assign ctl.push  = push;
    assign ctl.pop   = pop;

    assign do_push = push && !ctl.full;
    assign do_pop  = pop && !ctl.empty;

    assign pop_entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? QUEUE_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? QUEUE_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.full |-> !push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.empty |-> !pop)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");

endmodule

>>> design/annexb_back.sv
`timescale 1ns / 1ps
module annexb_back
    import annexb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  entry_t     head,
    input  logic       queue_empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output desc_t      out_desc
);

    logic  valid_reg, valid_next;
    logic  second_reg, second_next;
    desc_t desc_reg, desc_next;
    desc_t held_reg, held_next;
    logic  load;

    assign load      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_desc  = desc_reg;

    always_comb
    begin
        valid_next  = valid_reg;
        second_next = second_reg;
        desc_next   = desc_reg;
        held_next   = held_reg;
        pop         = 1'b0;
        if (load)
        begin
            if (second_reg)
            begin
                valid_next  = 1'b1;
                desc_next   = held_reg;
                second_next = 1'b0;
            end
            else if (!queue_empty)
            begin
                pop         = 1'b1;
                valid_next  = 1'b1;
                desc_next   = head.first;
                held_next   = head.second;
                second_next = head.two_results;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
        held_reg <= held_next;
    end

    a_second_after_first: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> (valid_reg && !desc_reg.last_result))
        else $error("second result pending without non-final first");

endmodule

>>> design/annexb_nal_unit_splitter.sv
`timescale 1ns / 1ps
// Annex B NAL unit splitter.
//
// bytes : one byte of an Annex B buffer per transfer, end_of_buffer high on
//         the buffer's last byte. Buffers follow each other with no gap.
// units : one NAL unit descriptor per transfer (type, offset, size), or a
//         single status=1 result when the buffer held no start code.
//         last_result marks the final result of each buffer.
//
// Throughput: one byte per clock while the queue has room. The front scanner
// classifies each byte in its accept cycle and writes the results it causes
// (one or two) as a single entry into a 4-entry queue; a byte that causes
// none writes nothing. The back end drains the queue through an output
// register at one result per clock while units.ready is high; a byte that
// closes one unit and ends the buffer gives two results, the closed unit first.
// Path: a byte's results enter the queue as the byte transfers, then the
// output register, where they go valid on units and transfer on units.ready.
// Stall: when units.ready is low the output register holds; the queue
// absorbs up to four result-bearing bytes, then bytes.ready drops until the
// back end frees an entry.
// Reset: rst_n clears scanner state, queue pointers and the output valid; the
// block takes a byte in the first cycle after reset with no clearing pass.
module annexb_nal_unit_splitter
    import annexb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    annexb_byte_if.sink        bytes,
    annexb_unit_if.source      units
);

    queue_ctl_t q_ctl;
    logic       push;
    logic       pop;
    entry_t     push_entry;
    entry_t     head;
    desc_t      out_desc;

    // Scanner: start code detection and unit bookkeeping.
    annexb_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (bytes.valid),
        .in_ready      (bytes.ready),
        .data_byte     (bytes.data_byte),
        .end_of_buffer (bytes.end_of_buffer),
        .queue_full    (q_ctl.full),
        .push          (push),
        .push_entry    (push_entry)
    );

    // Decoupling queue between scanner and output.
    annexb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (head),
        .ctl        (q_ctl)
    );

    // Output side: unrolls an entry into one or two result transfers.
    annexb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .queue_empty (q_ctl.empty),
        .pop         (pop),
        .out_valid   (units.valid),
        .out_ready   (units.ready),
        .out_desc    (out_desc)
    );

    assign units.unit_type   = out_desc.unit_type;
    assign units.unit_offset = out_desc.unit_offset;
    assign units.unit_size   = out_desc.unit_size;
    assign units.status      = out_desc.status;
    assign units.last_result = out_desc.last_result;

endmodule
